// ===== rtl/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP matcher.
// No dependencies; imported by the controller, the datapath and the top level.
package kmp_pkg;

    localparam int PAT_MAX  = 64;
    localparam int POS_BITS = 32;

    localparam int PAT_BITS = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;  // store index
    localparam int LEN_BITS = $clog2(PAT_MAX + 1);                  // 0..PAT_MAX

    localparam int START_BITS = 32;

    // request opcodes (cmd field)
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_SAT   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the request and issue the first table read
        logic finish;   // commit state updates and load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic step_done;  // failure walk has settled this cycle
    } t_dp_stat;

endpackage

// ===== rtl/kmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kmp_ctrl.sv =====
// Request sequencer: accept, walk the failure links, hand off the result.
// Depends on kmp_pkg (command and status structs).
module kmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  kmp_pkg::t_dp_stat i_stat,
    output kmp_pkg::t_dp_cmd  o_cmd
);
    import kmp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.step_done && out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/kmp_dp.sv =====
// Matcher datapath: pattern and border RAMs, walk register, counters, result.
// Depends on kmp_pkg and kmp_ram.
module kmp_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kmp_pkg::t_dp_cmd            i_ctl,
    output kmp_pkg::t_dp_stat           o_stat,
    input  logic                        i_cmd,
    input  logic                        i_restart,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_match_found,
    output logic [kmp_pkg::START_BITS-1:0] o_match_start,
    output logic                        o_any_match,
    output logic [1:0]                  o_status
);
    import kmp_pkg::*;

    localparam logic [POS_BITS-1:0] POS_TOP = {POS_BITS{1'b1}};

    // architectural state
    logic [LEN_BITS-1:0] r_len;
    logic [PAT_BITS-1:0] r_matched;
    logic [PAT_BITS-1:0] r_last_border;   // border of the last stored byte
    logic [POS_BITS-1:0] r_pos;
    logic                r_seen;

    // request in flight
    logic                r_op;
    logic [7:0]          r_b;
    logic                r_full;
    logic                r_nowalk;
    logic                r_sat;
    logic [POS_BITS-1:0] r_p;
    logic [LEN_BITS-1:0] r_m, n_m;

    // result register
    logic                  r_match_found;
    logic [START_BITS-1:0] r_match_start;
    logic                  r_any_match;
    logic [1:0]            r_status;

    logic [LEN_BITS-1:0] len_eff;
    logic [PAT_BITS-1:0] matched_eff;
    logic [POS_BITS-1:0] p_eff;
    logic                full_eff;
    logic                nowalk_eff;
    logic [LEN_BITS-1:0] m0;
    logic [LEN_BITS-1:0] m_final;
    logic [7:0]          pat_q;
    logic [PAT_BITS-1:0] brd_q;
    logic                hit;
    logic                we;
    logic                found;
    logic [POS_BITS-1:0] start_pos;

    // restart takes effect before the byte
    always_comb begin
        len_eff     = (i_cmd == CMD_LOAD && i_restart) ? '0 : r_len;
        matched_eff = (i_cmd == CMD_SCAN && i_restart) ? '0 : r_matched;
        p_eff       = (i_cmd == CMD_SCAN && i_restart) ? '0 : r_pos;
        full_eff    = (len_eff == LEN_BITS'(PAT_MAX));
        if (i_cmd == CMD_LOAD) begin
            nowalk_eff = (len_eff == '0) || full_eff;
            m0         = nowalk_eff ? '0 : LEN_BITS'(r_last_border);
        end else begin
            nowalk_eff = (r_len == '0);
            if (nowalk_eff || LEN_BITS'(matched_eff) >= r_len) begin
                m0 = '0;
            end else begin
                m0 = LEN_BITS'(matched_eff);
            end
        end
    end

    assign hit              = (pat_q == r_b);
    assign o_stat.step_done = r_nowalk || (r_m == '0) || hit;
    assign m_final          = (!r_nowalk && hit) ? r_m + LEN_BITS'(1) : r_m;

    // read address always tracks the next walk value
    always_comb begin
        if (i_ctl.accept) begin
            n_m = m0;
        end else if (!o_stat.step_done) begin
            n_m = LEN_BITS'(brd_q);
        end else begin
            n_m = r_m;
        end
    end

    assign we = i_ctl.finish && (r_op == CMD_LOAD) && !r_full;

    kmp_ram #(.WIDTH(8), .DEPTH(PAT_MAX)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_len[PAT_BITS-1:0]),
        .i_wdata (r_b),
        .i_raddr (n_m[PAT_BITS-1:0]),
        .o_rdata (pat_q)
    );

    // border[j] lives at address j; a walk at m reads border[m-1]
    kmp_ram #(.WIDTH(PAT_BITS), .DEPTH(PAT_MAX)) u_brd_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_len[PAT_BITS-1:0]),
        .i_wdata (m_final[PAT_BITS-1:0]),
        .i_raddr (PAT_BITS'(n_m - LEN_BITS'(1))),
        .o_rdata (brd_q)
    );

    assign found     = (r_len != '0) && (m_final == r_len);
    assign start_pos = r_p - POS_BITS'(r_len - LEN_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_matched     <= '0;
            r_last_border <= '0;
            r_pos         <= '0;
            r_seen        <= 1'b0;
        end else if (i_ctl.accept) begin
            if (i_cmd == CMD_LOAD) begin
                r_len     <= len_eff;
                r_matched <= '0;
            end else begin
                r_matched <= matched_eff;
                r_pos     <= (p_eff == POS_TOP) ? p_eff : p_eff + POS_BITS'(1);
                if (i_restart) begin
                    r_seen <= 1'b0;
                end
            end
        end else if (i_ctl.finish) begin
            if (r_op == CMD_LOAD) begin
                if (!r_full) begin
                    r_len         <= r_len + LEN_BITS'(1);
                    r_last_border <= m_final[PAT_BITS-1:0];
                end
            end else if (r_len != '0) begin
                if (found) begin
                    r_seen    <= 1'b1;
                    r_matched <= r_last_border;
                end else begin
                    r_matched <= m_final[PAT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
        if (i_ctl.accept) begin
            r_op     <= i_cmd;
            r_b      <= i_data_byte;
            r_full   <= full_eff;
            r_nowalk <= nowalk_eff;
            r_p      <= p_eff;
            r_sat    <= (p_eff == POS_TOP);
        end
        if (i_ctl.finish) begin
            if (r_op == CMD_LOAD) begin
                r_match_found <= 1'b0;
                r_match_start <= '0;
                r_any_match   <= r_seen;
                r_status      <= r_full ? STATUS_FULL : STATUS_OK;
            end else begin
                r_match_found <= found;
                r_match_start <= found ? START_BITS'(start_pos) : '0;
                r_any_match   <= r_seen || found;
                if (r_len == '0) begin
                    r_status <= STATUS_EMPTY;
                end else if (r_sat) begin
                    r_status <= STATUS_SAT;
                end else begin
                    r_status <= STATUS_OK;
                end
            end
        end
    end

    assign o_match_found = r_match_found;
    assign o_match_start = r_match_start;
    assign o_any_match   = r_any_match;
    assign o_status      = r_status;

endmodule

// ===== rtl/kmp_stream_matcher.sv =====
// Top level of the streaming KMP matcher: sequencer plus datapath.
// Depends on kmp_pkg, kmp_ctrl, kmp_dp (and kmp_ram through kmp_dp).
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------
//  request   | in        | i_valid / o_stall  | i_cmd, i_restart, i_data_byte
//  result    | out       | o_valid / i_stall  | o_match_found, o_match_start,
//            |           |                    | o_any_match, o_status
//
// Each request is accepted, walks its failure links and then finishes; the loop is
// bounded by the registered read of the pattern and border RAMs (one link a cycle).
// Synchronous active-low reset clears lengths, position and flags; the RAMs are
// not cleared (only written entries are ever read), so no sweep follows reset.
// A held result (i_stall high) does not block acceptance of the next request;
// that request waits at its final step until the result register frees up.
module kmp_stream_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic                           i_restart,
    input  logic [7:0]                     i_data_byte,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_match_found,
    output logic [kmp_pkg::START_BITS-1:0] o_match_start,
    output logic                           o_any_match,
    output logic [1:0]                     o_status
);
    import kmp_pkg::*;

    t_dp_cmd  ctl_cmd;
    t_dp_stat dp_stat;

    // sequencer: owns the state and the result valid bit
    kmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd)
    );

    // datapath: tables, walk register, counters and result payload
    kmp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl_cmd),
        .o_stat        (dp_stat),
        .i_cmd         (i_cmd),
        .i_restart     (i_restart),
        .i_data_byte   (i_data_byte),
        .o_match_found (o_match_found),
        .o_match_start (o_match_start),
        .o_any_match   (o_any_match),
        .o_status      (o_status)
    );

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.finish |-> (!o_valid || !i_stall))
        else $error("result register overwritten while held");

    // an accepted request holds off the next until it finishes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.accept |=> (o_stall && !ctl_cmd.accept))
        else $error("request accepted while another is in flight");

    // a reported match sets the sticky flag in the same result
    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_match_found) |-> o_any_match)
        else $error("match reported without sticky flag");

    // an empty pattern or a load never reports a match
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_match_found) |-> (o_status == STATUS_OK || o_status == STATUS_SAT))
        else $error("match reported with load or empty-pattern status");
`endif

endmodule
